// ===== hw/rtl/fa_pkg.sv =====
`default_nettype none
package fa_pkg;

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_TOUCH = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFRAME = 2'd1,
		ST_BADIDX  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SCAN = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] owner_id;
		logic [15:0] virtual_page;
		logic [7:0]  frame_index;
		logic [31:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  granted_frame;
		logic        did_evict;
		logic [15:0] evicted_owner;
		logic [15:0] evicted_page;
		logic        frame_in_use;
		logic [6:0]  free_total;
		logic [5:0]  free_runs;
	} rsp_t;

	// one frame's contents as it circulates round the ring
	typedef struct packed {
		logic        used;
		logic [15:0] owner;
		logic [15:0] vpage;
		logic [31:0] stamp;
	} frame_t;

endpackage
`default_nettype wire

// ===== hw/rtl/frame_allocator_lru_evict.sv =====
`default_nettype none
// Frame allocator with oldest-first eviction.
// Command channel: a cmd item (cmd_t) is taken on a clock edge with start high
// and busy low. Result channel: one rsp_t item per command, shown on rsp for
// exactly one cycle while done is high; the receiver cannot hold it off.
// The frame table sits in a ring of FRAMES cells. A command rotates the ring
// one full turn to find the lowest free frame, the eviction victim and the
// free count and runs. A second full turn rewrites the frame
// at the head cell as it passes back into the tail cell, and recounts.
// Busy stays high throughout a command, so no new command is taken until the
// last one is finished.
// Reset empties every frame and returns the block to idle at once.
module frame_allocator_lru_evict
	import fa_pkg::*;
#(
	parameter int FRAMES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	frame_t cell_out [FRAMES];
	frame_t head_d;
	logic   head_ld;
	logic   shift;

	genvar g;
	generate
		for (g = 0; g < FRAMES; g++) begin : g_ring
			fa_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.load(head_ld && g == FRAMES - 1), .load_d(head_d),
				.prev(cell_out[(g + 1) % FRAMES]), .cur(cell_out[g])
			);
		end
	endgenerate

	phase_t       ph_q, ph_d;
	logic         pass_q;
	logic [IW-1:0] pos_q;
	cmd_t         cmd_q;
	logic         free_fnd_q, vic_fnd_q;
	logic [IW-1:0] free_idx_q, vic_idx_q;
	logic [31:0]  vic_time_q;
	logic [15:0]  vic_own_q, vic_pg_q;
	logic [CW-1:0] fcnt_q;
	logic [CW-1:0] runs_q;
	logic         prev_free_q;
	logic         mark_q;
	rsp_t         rsp_d;
	rsp_t         rsp_q;
	logic         done_q;

	frame_t hd;
	logic   valid_idx, is_free, last;
	logic   alloc_hit, free_hit, touch_hit, grant_ok;
	logic [IW-1:0] pick;

	assign hd        = cell_out[0];
	assign valid_idx = {24'd0, cmd_q.frame_index} < 32'(FRAMES);
	assign last      = pos_q == IW'(FRAMES - 1);
	assign pick      = free_fnd_q ? free_idx_q : vic_idx_q;
	assign grant_ok  = free_fnd_q || vic_fnd_q;
	assign alloc_hit = cmd_q.func == FUNC_ALLOC && grant_ok && pos_q == pick;
	assign free_hit  = cmd_q.func == FUNC_FREE && valid_idx &&
		pos_q == cmd_q.frame_index[IW-1:0];
	assign touch_hit = cmd_q.func == FUNC_TOUCH && valid_idx && hd.used &&
		pos_q == cmd_q.frame_index[IW-1:0];

	// rewritten frame for the head cell during the update turn
	always_comb begin
		head_d = hd;
		if (alloc_hit) begin
			head_d = '{used: 1'b1, owner: cmd_q.owner_id,
				vpage: cmd_q.virtual_page, stamp: cmd_q.now_time};
		end else if (free_hit) begin
			head_d = '{used: 1'b0, owner: 16'd0, vpage: 16'd0, stamp: hd.stamp};
		end else if (touch_hit) begin
			head_d.stamp = cmd_q.now_time;
		end
	end

	assign is_free = pass_q ? !head_d.used : !hd.used;
	assign shift   = ph_q == PH_SCAN;
	assign head_ld = shift && pass_q && (alloc_hit || free_hit || touch_hit);

	// next phase
	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			PH_IDLE: if (start) ph_d = PH_SCAN;
			PH_SCAN: if (pass_q && last) ph_d = PH_DONE;
			PH_DONE: ph_d = PH_IDLE;
			default: ph_d = PH_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		busy = ph_q != PH_IDLE;
		done = done_q;
		rsp  = rsp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			pass_q <= 1'b0;
			pos_q  <= '0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			done_q <= ph_q == PH_DONE;
			if (shift) begin
				pos_q <= last ? '0 : pos_q + 1'b1;
				if (last) pass_q <= !pass_q;
			end
		end
	end

	// scan bookkeeping on the head cell
	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			cmd_q       <= cmd;
			free_fnd_q  <= 1'b0;
			vic_fnd_q   <= 1'b0;
			fcnt_q      <= '0;
			runs_q      <= '0;
			prev_free_q <= 1'b0;
			mark_q      <= 1'b0;
		end else if (shift) begin
			if (last) begin
				prev_free_q <= 1'b0;
			end else begin
				prev_free_q <= is_free;
			end
			if (pos_q == 0) begin
				fcnt_q <= CW'(is_free);
				runs_q <= CW'(is_free);
			end else begin
				fcnt_q <= fcnt_q + CW'(is_free);
				runs_q <= runs_q + CW'(is_free && !prev_free_q);
			end
			if (!pass_q) begin
				if (!hd.used && !free_fnd_q) begin
					free_fnd_q <= 1'b1;
					free_idx_q <= pos_q;
				end
				if (hd.used && hd.owner != 16'd0 &&
					(!vic_fnd_q || hd.stamp < vic_time_q)) begin
					vic_fnd_q  <= 1'b1;
					vic_idx_q  <= pos_q;
					vic_time_q <= hd.stamp;
					vic_own_q  <= hd.owner;
					vic_pg_q   <= hd.vpage;
				end
			end else if (pos_q == cmd_q.frame_index[IW-1:0]) begin
				mark_q <= !is_free;
			end
		end
	end

	// result assembly
	always_comb begin
		rsp_d = '0;
		rsp_d.free_total   = 7'(fcnt_q);
		rsp_d.free_runs    = 6'(runs_q);
		rsp_d.frame_in_use = valid_idx && mark_q;
		if (cmd_q.func == FUNC_ALLOC) begin
			if (grant_ok) begin
				rsp_d.status        = ST_OK;
				rsp_d.granted_frame = 6'(pick);
				if (!free_fnd_q) begin
					rsp_d.did_evict     = 1'b1;
					rsp_d.evicted_owner = vic_own_q;
					rsp_d.evicted_page  = vic_pg_q;
				end
			end else begin
				rsp_d.status = ST_NOFRAME;
			end
		end else if (!valid_idx) begin
			rsp_d.status = ST_BADIDX;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ph_q == PH_DONE) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/fa_cell.sv =====
`default_nettype none
module fa_cell
	import fa_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   shift,
	input  wire logic   load,
	input  wire frame_t load_d,
	input  wire frame_t prev,
	output frame_t      cur
);

	frame_t frm_q;

	// rotate one place per cycle while shift is high, or take a rewritten frame when load is high (the tail cell)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_q <= '0;
		end else if (load) begin
			frm_q <= load_d;
		end else if (shift) begin
			frm_q <= prev;
		end
	end

	assign cur = frm_q;

endmodule
`default_nettype wire
